// ===== rtl/core/ept_pkg.sv =====
// Eased position transition: shared types, codes and widths.
// No dependencies; used by every module in rtl/core.
package ept_pkg;

    localparam int POS_W = 32;
    localparam int DUR_W = 24;
    localparam int DT_W  = 16;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_TICK   = 2'd1,
        OP_CANCEL = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_DEF_DUR  = 2'd0,
        CFG_SPR_EN   = 2'd1,
        CFG_SPR_STR  = 2'd2,
        CFG_SPR_DAMP = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]        op;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
        logic [23:0]       duration;
        logic signed [31:0] live_x;
        logic signed [31:0] live_y;
        logic signed [31:0] live_z;
        logic [15:0]       delta_time;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic              pos_written;
        logic              in_progress;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_EVAL,
        ST_SQ,
        ST_T,
        ST_LERP,
        ST_FORCE,
        ST_VEL,
        ST_POS,
        ST_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;      // take the input item
        logic div_start;
        logic div_step;
        logic eval;      // compare progress, snap or advance
        logic sq;
        logic tmul;
        logic lerp;
        logic frc;       // spring force for one axis
        logic vel;
        logic pos;
        logic emit;
        logic [1:0] axis;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic done_div;
        logic finish;  // tick completes
        logic spring;
    } t_status;

endpackage

// ===== rtl/core/ept_ctrl.sv =====
// Eased position transition: controller state machine.
// Depends on ept_pkg.
module ept_ctrl import ept_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic [1:0] i_op,
    input  logic    i_active,
    input  logic    i_out_busy,
    output logic    o_in_ready,
    input  t_status i_stat,
    output t_cmd    o_cmd
);

    t_state     r_state, n_state;
    logic [1:0] r_axis, n_axis;
    logic       acc;

    assign acc = i_in_valid && o_in_ready;

    // next state
    always_comb begin
        n_state = r_state;
        n_axis  = r_axis;
        unique case (r_state)
            ST_IDLE: begin
                if (acc && i_op == OP_TICK && i_active) n_state = ST_DIV;
                else if (acc) n_state = ST_OUT;
            end
            ST_DIV:  if (i_stat.done_div) n_state = ST_EVAL;
            ST_EVAL: n_state = i_stat.finish ? ST_OUT : ST_SQ;
            ST_SQ:   n_state = ST_T;
            ST_T: begin
                n_state = ST_LERP;
                n_axis  = 2'd0;
            end
            ST_LERP: begin
                if (r_axis == 2'd2) begin
                    n_axis  = 2'd0;
                    n_state = i_stat.spring ? ST_FORCE : ST_OUT;
                end else n_axis = r_axis + 2'd1;
            end
            ST_FORCE: n_state = ST_VEL;
            ST_VEL:   n_state = ST_POS;
            ST_POS: begin
                if (r_axis == 2'd2) begin
                    n_state = ST_OUT;
                    n_axis  = 2'd0;
                end else begin
                    n_axis  = r_axis + 2'd1;
                    n_state = ST_FORCE;
                end
            end
            ST_OUT:  if (!i_out_busy) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd = '0;
        o_cmd.axis = r_axis;
        o_in_ready = (r_state == ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.load      = acc;
                o_cmd.div_start = acc;
            end
            ST_DIV:   o_cmd.div_step = 1'b1;
            ST_EVAL:  o_cmd.eval = 1'b1;
            ST_SQ:    o_cmd.sq = 1'b1;
            ST_T:     o_cmd.tmul = 1'b1;
            ST_LERP:  o_cmd.lerp = 1'b1;
            ST_FORCE: o_cmd.frc = 1'b1;
            ST_VEL:   o_cmd.vel = 1'b1;
            ST_POS:   o_cmd.pos = 1'b1;
            ST_OUT:   o_cmd.emit = !i_out_busy;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_axis  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV && !i_stat.done_div |=> r_state == ST_DIV)
        else $error("divider left early");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_state == ST_IDLE)
        else $error("ready outside idle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EVAL && i_stat.finish |=> r_state == ST_OUT)
        else $error("snap did not go to output");

endmodule

// ===== rtl/core/ept_dp.sv =====
// Eased position transition: datapath (state, divider, multiplier, output reg).
// Depends on ept_pkg.
module ept_dp import ept_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_item,
    input  t_cmd      i_cmd,
    input  logic      i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    input  logic      i_out_ready,
    output logic      o_out_valid,
    output t_out_item o_out,
    output logic      o_active,
    output t_status   o_stat
);
    localparam int PW = FRAC_BITS + 1;          // progress width
    localparam int QW = DT_W + FRAC_BITS;       // quotient width
    localparam int CW = $clog2(QW + 1);
    localparam logic [PW-1:0] ONE = PW'(1) << FRAC_BITS;

    logic [23:0] r_def_dur;
    logic        r_spr_en;
    logic [15:0] r_spr_str, r_spr_damp;

    logic               r_active;
    logic [PW-1:0]      r_prog;
    logic [23:0]        r_run_dur;
    logic signed [31:0] r_src [3];
    logic signed [31:0] r_tgt [3];
    logic signed [31:0] r_vel [3];
    logic [15:0]        r_dt;

    // restoring divider: (dt << FRAC_BITS) / run_duration
    logic [QW-1:0] r_num, r_quo;
    logic [24:0]   r_rem;
    logic [CW-1:0] r_cnt;
    logic [24:0]   rem_sh;
    assign rem_sh = {r_rem[23:0], r_num[QW-1]};

    // work registers
    logic [PW-1:0]      r_x2;
    logic [PW+1:0]      r_t;
    logic signed [31:0] r_p [3];
    logic signed [47:0] r_force;
    logic signed [33:0] r_fac;
    logic signed [63:0] r_vn;

    t_out_item r_res;   // result being built
    t_out_item r_out;   // result on offer
    logic      r_ov;
    logic      ld_ip;

    // comb helpers
    logic [QW:0]        np;
    logic signed [33:0] diff;
    logic signed [67:0] dprod;
    logic signed [33:0] disp;
    logic signed [50:0] fprod;
    logic signed [63:0] v1, v2;
    logic signed [63:0] vsum;
    logic signed [31:0] vsat;
    logic [31:0]        dmp;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)       sat32 = 32'sh7fffffff;
        else if (v < -64'sd2147483648) sat32 = 32'sh80000000;
        else                           sat32 = v[31:0];
    endfunction

    assign np   = {{(QW+1-PW){1'b0}}, r_prog} + {1'b0, r_quo};
    assign diff = 34'(r_tgt[i_cmd.axis]) - 34'(r_src[i_cmd.axis]);
    assign dprod = 68'(diff) * $signed({1'b0, r_t});
    assign disp = 34'(r_tgt[i_cmd.axis]) - 34'(r_p[i_cmd.axis]);
    assign fprod = 51'(disp) * $signed({1'b0, r_spr_str});
    assign dmp  = 32'(r_spr_damp) * 32'(r_dt);
    assign v1   = (64'(r_vel[i_cmd.axis]) * 64'(r_fac)) >>> FRAC_BITS;
    assign v2   = (64'(r_force) * $signed({1'b0, r_dt})) >>> FRAC_BITS;
    assign vsum = r_vn;
    assign vsat = sat32(vsum);

    // in_progress of the result for a newly taken item
    always_comb begin
        unique case (t_op'(i_item.op))
            OP_START:  ld_ip = 1'b1;
            OP_CANCEL: ld_ip = 1'b0;
            OP_TICK:   ld_ip = r_active;
            OP_NONE:   ld_ip = r_active;
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_dur  <= 24'd32768;
            r_spr_en   <= 1'b0;
            r_spr_str  <= 16'd2560;
            r_spr_damp <= 16'd205;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_DEF_DUR:  r_def_dur  <= i_cfg_data;
                CFG_SPR_EN:   r_spr_en   <= i_cfg_data[0];
                CFG_SPR_STR:  r_spr_str  <= i_cfg_data[15:0];
                CFG_SPR_DAMP: r_spr_damp <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // transition state and datapath steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_prog    <= '0;
            r_run_dur <= 24'd32768;
            for (int i = 0; i < 3; i++) begin
                r_src[i] <= '0;
                r_tgt[i] <= '0;
                r_vel[i] <= '0;
            end
            r_ov <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_dt  <= i_item.delta_time;
                r_res <= {96'd0, 1'b0, ld_ip};
                unique case (t_op'(i_item.op))
                    OP_START: begin
                        if (!r_active) begin
                            r_src[0] <= i_item.live_x;
                            r_src[1] <= i_item.live_y;
                            r_src[2] <= i_item.live_z;
                        end
                        r_tgt[0] <= i_item.target_x;
                        r_tgt[1] <= i_item.target_y;
                        r_tgt[2] <= i_item.target_z;
                        for (int i = 0; i < 3; i++) r_vel[i] <= '0;
                        r_prog    <= '0;
                        r_run_dur <= (i_item.duration != '0) ? i_item.duration : r_def_dur;
                        r_active  <= 1'b1;
                    end
                    OP_CANCEL: r_active <= 1'b0;
                    OP_TICK:   ;
                    OP_NONE:   ;
                    default: ;
                endcase
            end
            if (i_cmd.div_start) begin
                r_num <= QW'(i_item.delta_time) << FRAC_BITS;
                r_rem <= '0;
                r_quo <= '0;
                r_cnt <= CW'(QW);
            end
            if (i_cmd.div_step && r_cnt != '0) begin
                r_num <= r_num << 1;
                r_cnt <= r_cnt - 1'b1;
                if (rem_sh >= {1'b0, r_run_dur}) begin
                    r_rem <= rem_sh - {1'b0, r_run_dur};
                    r_quo <= {r_quo[QW-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh;
                    r_quo <= {r_quo[QW-2:0], 1'b0};
                end
            end
            if (i_cmd.eval) begin
                if (o_stat.finish) begin
                    // snap to target, transition ends
                    r_active <= 1'b0;
                    r_prog   <= ONE;
                    r_res    <= {r_tgt[0], r_tgt[1], r_tgt[2], 1'b1, 1'b0};
                end else begin
                    r_prog <= np[PW-1:0];
                    r_fac  <= 34'(ONE) - $signed({2'b0, dmp >> 8});
                end
            end
            if (i_cmd.sq) r_x2 <= PW'((2*PW)'(r_prog) * (2*PW)'(r_prog) >> FRAC_BITS);
            if (i_cmd.tmul)
                r_t <= (PW+2)'(((2*PW+2)'(r_x2) * ((2*PW+2)'(3 * ONE) -
                       (2*PW+2)'({r_prog, 1'b0}))) >> FRAC_BITS);
            if (i_cmd.lerp) begin
                r_p[i_cmd.axis] <= r_src[i_cmd.axis] + 32'(dprod >>> FRAC_BITS);
                // positions come from r_p when the result is sent
                if (i_cmd.axis == 2'd2) r_res <= {96'd0, 2'b11};
            end
            if (i_cmd.frc) begin
                if ((fprod >>> 8) > 51'sh7fffffffffff)       r_force <= 48'sh7fffffffffff;
                else if ((fprod >>> 8) < -51'sh800000000000) r_force <= 48'sh800000000000;
                else                                         r_force <= 48'(fprod >>> 8);
            end
            if (i_cmd.vel) r_vn <= v1 + v2;
            if (i_cmd.pos) begin
                r_vel[i_cmd.axis] <= vsat;
                r_p[i_cmd.axis]   <= sat32(64'(r_p[i_cmd.axis]) +
                    64'((49'(vsat) * $signed({1'b0, r_dt})) >>> FRAC_BITS));
            end
            // output register: load a new result or drop the one taken
            if (i_cmd.emit) begin
                r_ov <= 1'b1;
                if (r_res.pos_written && r_res.in_progress)
                    r_out <= {r_p[0], r_p[1], r_p[2], 2'b11};
                else
                    r_out <= r_res;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_stat.done_div = (r_cnt == '0);
    assign o_stat.finish   = (r_run_dur == '0) || (np >= (QW+1)'(ONE));
    assign o_stat.spring   = r_spr_en;
    assign o_out_valid = r_ov;
    assign o_out       = r_out;
    assign o_active    = r_active;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> !r_ov || i_out_ready)
        else $error("output overwritten");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prog <= ONE)
        else $error("progress above one");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.eval && o_stat.finish |=> !r_active)
        else $error("snap left active");
endmodule

// ===== rtl/core/eased_position_transition.sv =====
// Eased position transition top level: controller plus datapath.
// Depends on ept_pkg, ept_ctrl, ept_dp.
//
//  channel | signals                          | payload
//  in      | i_in_valid / o_in_ready          | t_in_item
//  out     | o_out_valid / i_out_ready        | t_out_item
//  cfg     | i_cfg_we, i_cfg_idx, i_cfg_data  | 24-bit write
//
// Start, cancel and idle ticks go straight to output. An active tick runs the
// 32-step restoring divider for dt/duration, then evaluate, square, smoothstep,
// 3 lerp steps and output; with the spring on, force, velocity and position
// steps for each axis follow the lerps. A completing tick snaps after evaluate.
// Reset is synchronous, active low. The result sits in its own register, so a
// stalled result holds the block only once the next result is ready to leave.
module eased_position_transition import ept_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data
);
    t_cmd    cmd;
    t_status stat;
    logic    active;

    ept_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .i_op(i_in_data.op), .i_active(active),
        .i_out_busy(o_out_valid && !i_out_ready), .o_in_ready,
        .i_stat(stat), .o_cmd(cmd)
    );

    ept_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk, .i_rst_n, .i_item(i_in_data), .i_cmd(cmd),
        .i_cfg_we, .i_cfg_idx, .i_cfg_data, .i_out_ready,
        .o_out_valid, .o_out(o_out_data), .o_active(active), .o_stat(stat)
    );
endmodule

// ===== verif/eased_position_transition_check.sv =====
`timescale 1ns / 100ps
// Checker for the eased position transition: watches the in, out and cfg ports,
// predicts each result in Q16.16 fixed point and compares it in order.
// Depends on ept_pkg.
module eased_position_transition_check import ept_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in_item    i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out_item   i_out_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    localparam longint ONE = 64'sd65536;

    // mirrored configuration
    logic [23:0] def_dur;
    logic        spr_en;
    logic [15:0] spr_str;
    logic [15:0] spr_damp;

    // mirrored transition state
    logic               running;
    logic [16:0]        prog;
    logic [23:0]        run_dur;
    logic signed [31:0] src_pos [3];
    logic signed [31:0] tgt_pos [3];
    logic signed [31:0] vel [3];

    t_out_item expected_pos_q [$];

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint sat32(longint v);
        return clamp(v, -64'sd2147483648, 64'sd2147483647);
    endfunction

    // advance the mirrored state by one transfer and return the position it yields
    function automatic t_out_item next_position(t_in_item it);
        t_out_item r;
        longint unsigned np, x, x2;
        longint t, dt, factor, diff, disp, frc, v;
        longint p [3];
        r = '0;
        dt = longint'(it.delta_time);
        case (t_op'(it.op))
            OP_START: begin
                if (!running) begin
                    src_pos[0] = it.live_x;
                    src_pos[1] = it.live_y;
                    src_pos[2] = it.live_z;
                end
                tgt_pos[0] = it.target_x;
                tgt_pos[1] = it.target_y;
                tgt_pos[2] = it.target_z;
                for (int i = 0; i < 3; i++) vel[i] = '0;
                prog = '0;
                run_dur = (it.duration != 0) ? it.duration : def_dur;
                running = 1'b1;
                r.in_progress = 1'b1;
            end
            OP_CANCEL: begin
                running = 1'b0;
            end
            OP_NONE: begin
                r.in_progress = running;
            end
            default: begin
                if (running) begin
                    if (run_dur == 0)
                        np = ONE;
                    else
                        np = longint'(prog) + ((longint'(it.delta_time) << 16) / run_dur);
                    if (np >= ONE) begin
                        // completion: snap to target, clamp progress
                        running = 1'b0;
                        prog = 17'h10000;
                        r.pos_x = tgt_pos[0];
                        r.pos_y = tgt_pos[1];
                        r.pos_z = tgt_pos[2];
                        r.pos_written = 1'b1;
                    end else begin
                        prog = np[16:0];
                        x  = prog;
                        x2 = (x * x) >> 16;
                        t  = longint'((x2 * (3 * ONE - 2 * x)) >> 16);
                        for (int i = 0; i < 3; i++) begin
                            diff = longint'(tgt_pos[i]) - longint'(src_pos[i]);
                            p[i] = longint'(src_pos[i]) + ((diff * t) >>> 16);
                        end
                        if (spr_en) begin
                            factor = ONE - ((longint'(spr_damp) * dt) >>> 8);
                            for (int i = 0; i < 3; i++) begin
                                disp = longint'(tgt_pos[i]) - p[i];
                                frc  = clamp((disp * longint'(spr_str)) >>> 8,
                                             -(64'sd1 <<< 47), (64'sd1 <<< 47) - 1);
                                v = ((longint'(vel[i]) * factor) >>> 16) + ((frc * dt) >>> 16);
                                vel[i] = sat32(v);
                                p[i] = sat32(p[i] + ((longint'(vel[i]) * dt) >>> 16));
                            end
                        end
                        r.pos_x = p[0];
                        r.pos_y = p[1];
                        r.pos_z = p[2];
                        r.pos_written = 1'b1;
                        r.in_progress = 1'b1;
                    end
                end
            end
        endcase
        return r;
    endfunction

    task automatic report(string field, longint exp_v, longint act_v);
        $display("%0t: mismatch on %s: expected %0d, got %0d", $time, field, exp_v, act_v);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_out_item e;
        if (!i_rst_n) begin
            def_dur  = 24'd32768;
            spr_en   = 1'b0;
            spr_str  = 16'd2560;
            spr_damp = 16'd205;
            running  = 1'b0;
            prog     = '0;
            run_dur  = 24'd32768;
            for (int i = 0; i < 3; i++) begin
                src_pos[i] = '0;
                tgt_pos[i] = '0;
                vel[i]     = '0;
            end
            o_fail_count = 0;
            o_pending    <= 0;
        end else begin
            // register writes
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_DEF_DUR:  def_dur  = i_cfg_data;
                    CFG_SPR_EN:   spr_en   = i_cfg_data[0];
                    CFG_SPR_STR:  spr_str  = i_cfg_data[15:0];
                    CFG_SPR_DAMP: spr_damp = i_cfg_data[15:0];
                endcase
            end
            // input transfer: predict
            if (i_in_valid && i_in_ready)
                expected_pos_q.push_back(next_position(i_in_data));
            // output transfer: compare with the oldest expectation
            if (i_out_valid && i_out_ready) begin
                if (expected_pos_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, i_out_data);
                    o_fail_count++;
                end else begin
                    e = expected_pos_q.pop_front();
                    if (e.pos_x != i_out_data.pos_x) report("pos_x", e.pos_x, i_out_data.pos_x);
                    if (e.pos_y != i_out_data.pos_y) report("pos_y", e.pos_y, i_out_data.pos_y);
                    if (e.pos_z != i_out_data.pos_z) report("pos_z", e.pos_z, i_out_data.pos_z);
                    if (e.pos_written != i_out_data.pos_written)
                        report("pos_written", e.pos_written, i_out_data.pos_written);
                    if (e.in_progress != i_out_data.in_progress)
                        report("in_progress", e.in_progress, i_out_data.in_progress);
                end
            end
            o_pending <= expected_pos_q.size();
        end
    end

endmodule

// ===== verif/eased_position_transition_test.sv =====
`timescale 1ns / 100ps
// Testbench top for the eased position transition: clock, reset, stimulus
// and verdict. Depends on ept_pkg, eased_position_transition and its checker.
module eased_position_transition_test;
    import ept_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_in_item    in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_item   out_data;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_idx = CFG_DEF_DUR;
    logic [23:0] cfg_data = '0;
    int          fail_count;
    int          pending;

    int send_idle = 37;
    int recv_idle = 63;
    int n_in = 0;
    int n_items = 0;

    always #5 i_clk = ~i_clk;

    eased_position_transition DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    eased_position_transition_check checker_u (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // count input transfers
    always @(posedge i_clk)
        if (in_valid && in_ready) n_in <= n_in + 1;

    // receiver stalls
    always @(negedge i_clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle);

    // run limit
    initial begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic send(input t_in_item it);
        int c0;
        if ($urandom_range(0, 99) < send_idle)
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        in_data  = it;
        in_valid = 1'b1;
        c0 = n_in;
        do @(negedge i_clk); while (n_in == c0);
        in_valid = 1'b0;
        n_items++;
    endtask

    // pause until every expected result has come, then let the block settle
    task automatic drain();
        while (pending != 0 || in_valid) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [23:0] val);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = val;
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    function automatic t_in_item make_item(t_op op, logic [23:0] dur, logic [15:0] dt);
        t_in_item it;
        it.op = op;
        it.target_x = $urandom;
        it.target_y = $urandom;
        it.target_z = $urandom;
        it.duration = dur;
        it.live_x = $urandom;
        it.live_y = $urandom;
        it.live_z = $urandom;
        it.delta_time = dt;
        return it;
    endfunction

    function automatic logic [23:0] rand_dur();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 20) return 24'($urandom_range(1, 24'hFFFFFF));
        return 24'($urandom_range(1, 1 << 18));
    endfunction

    function automatic logic [15:0] rand_dt();
        if ($urandom_range(0, 99) < 70) return 16'($urandom_range(0, 65535));
        return 16'($urandom_range(0, 4096));
    endfunction

    // well-formed start/tick runs with random content, plus noise
    task automatic run_random(input int n);
        int stop_at, k, r;
        stop_at = n_items + n;
        while (n_items < stop_at) begin
            send(make_item(OP_START, rand_dur(), rand_dt()));
            k = $urandom_range(1, 8);
            repeat (k) begin
                r = $urandom_range(0, 99);
                if (r < 6)       send(make_item(OP_CANCEL, rand_dur(), rand_dt()));
                else if (r < 10) send(make_item(OP_NONE, rand_dur(), rand_dt()));
                else if (r < 15) send(make_item(OP_START, rand_dur(), rand_dt()));
                else             send(make_item(OP_TICK, rand_dur(), rand_dt()));
            end
        end
    endtask

    initial begin
        t_in_item it;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: idle cases, extremes, retarget, default duration
        send(make_item(OP_TICK, 24'd0, 16'hFFFF));
        send(make_item(OP_CANCEL, 24'd0, 16'd0));
        send(make_item(OP_NONE, 24'd0, 16'd0));
        it = make_item(OP_START, 24'd0, 16'd0);
        it.target_x = 32'sh7FFFFFFF; it.target_y = 32'sh80000000; it.target_z = 32'sh7FFFFFFF;
        it.live_x = 32'sh80000000; it.live_y = 32'sh7FFFFFFF; it.live_z = 32'sh80000000;
        send(it);
        send(make_item(OP_TICK, 24'd0, 16'd0));
        send(make_item(OP_TICK, 24'd0, 16'd8192));
        send(make_item(OP_NONE, 24'd0, 16'd0));
        send(make_item(OP_START, 24'd131072, 16'd0));   // retarget keeps source
        send(make_item(OP_TICK, 24'd0, 16'd30000));
        send(make_item(OP_TICK, 24'd0, 16'hFFFF));      // large step, still short of the target
        send(make_item(OP_TICK, 24'd0, 16'd100));
        send(make_item(OP_START, 24'd1, 16'd0));
        send(make_item(OP_TICK, 24'd0, 16'd1));
        send(make_item(OP_START, 24'hFFFFFF, 16'd0));
        send(make_item(OP_TICK, 24'd0, 16'hFFFF));
        send(make_item(OP_CANCEL, 24'd0, 16'd0));
        send(make_item(OP_TICK, 24'd0, 16'd500));

        // spring on, hard spring, no damping
        drain();
        write_reg(CFG_DEF_DUR, 24'd1);
        write_reg(CFG_SPR_EN, 24'd1);
        write_reg(CFG_SPR_STR, 24'hFFFF);
        write_reg(CFG_SPR_DAMP, 24'd0);
        run_random(80);
        drain();                       // sender holds until all results arrive
        run_random(80);

        // zero default duration, full damping, no stiffness
        send_idle = 63;
        recv_idle = 37;
        drain();
        write_reg(CFG_DEF_DUR, 24'd0);
        write_reg(CFG_SPR_STR, 24'd0);
        write_reg(CFG_SPR_DAMP, 24'hFFFF);
        run_random(160);

        // spring off, longest default, no idling
        send_idle = 0;
        recv_idle = 0;
        drain();
        write_reg(CFG_DEF_DUR, 24'hFFFFFF);
        write_reg(CFG_SPR_EN, 24'd0);
        write_reg(CFG_SPR_STR, 24'd2560);
        write_reg(CFG_SPR_DAMP, 24'd205);
        run_random(160);

        drain();
        $display("Ran %0d transfers: idle/start/cancel cases, snaps, retargets,", n_items);
        $display("spring on and off, zero and maximum default duration, mixed stalls.");
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/ept_pkg.sv
rtl/core/ept_ctrl.sv
rtl/core/ept_dp.sv
rtl/core/eased_position_transition.sv
verif/eased_position_transition_check.sv
verif/eased_position_transition_test.sv
